>>> hdl/tct_pkg.sv
package tct_pkg;

   // Field widths.
   localparam int RAW_W     = 16;
   localparam int CAL_W     = 16;
   localparam int LIM_W     = 11;
   localparam int TEMP_W    = 16;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 3;

   // Datapath widths, each sized to the range of its value.
   localparam int DIFF_W     = RAW_W + 1;
   localparam int PROD_W     = 2 * DIFF_W;
   localparam int PROD_SHIFT = 15;
   localparam int X1_W       = PROD_W - PROD_SHIFT;
   localparam int DEN_W      = X1_W + 1;
   localparam int MC_SHIFT   = 11;
   localparam int NUM_W      = CAL_W + MC_SHIFT;
   localparam int QUO_W      = NUM_W + 1;
   localparam int SUM_W      = QUO_W + 1;
   localparam int T_SHIFT    = 4;
   localparam int T_W        = SUM_W - T_SHIFT;

   // Four stages ahead of the divider, one per quotient bit, four behind it.
   localparam int LATENCY = NUM_W + 8;

   localparam logic [CAL_W-1:0] CAL_AC5_RESET    = 16'd32757;
   localparam logic [CAL_W-1:0] CAL_AC6_RESET    = 16'd23153;
   localparam logic [CAL_W-1:0] CAL_MC_RESET     = 16'hDDF9;
   localparam logic [CAL_W-1:0] CAL_MD_RESET     = 16'd2868;
   localparam logic [LIM_W-1:0] LIMIT_HIGH_RESET = 11'd300;
   localparam logic [LIM_W-1:0] LIMIT_LOW_RESET  = 11'd200;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAL_AC5    = 3'd0,
      CSR_CAL_AC6    = 3'd1,
      CSR_CAL_MC     = 3'd2,
      CSR_CAL_MD     = 3'd3,
      CSR_LIMIT_HIGH = 3'd4,
      CSR_LIMIT_LOW  = 3'd5
   } csr_index_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_DIV_ZERO  = 2'd1,
      STATUS_SATURATED = 2'd2
   } status_type;

   // Side data that rides along with a transaction through the divider.
   typedef struct packed {
      logic signed [X1_W-1:0] x1;
      logic                   div_zero;
      logic                   quo_neg;
   } div_tag_type;

endpackage

>>> hdl/tct_divider.sv
module tct_divider import tct_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0] in_den,
   input  div_tag_type      in_tag,
   output logic             out_valid,
   output logic [NUM_W-1:0] out_quo,
   output div_tag_type      out_tag
);

   // Restoring unsigned division, one quotient bit per pipeline stage.
   logic             vld_ff  [NUM_W];
   logic [NUM_W-1:0] num_ff  [NUM_W];
   logic [NUM_W-1:0] quo_ff  [NUM_W];
   logic [DEN_W-1:0] rem_ff  [NUM_W];
   logic [DEN_W-1:0] den_ff  [NUM_W];
   div_tag_type      tag_ff  [NUM_W];

   logic             vld_in  [NUM_W];
   logic [NUM_W-1:0] num_in  [NUM_W];
   logic [NUM_W-1:0] quo_in  [NUM_W];
   logic [DEN_W-1:0] rem_in  [NUM_W];
   logic [DEN_W-1:0] den_in  [NUM_W];
   div_tag_type      tag_in  [NUM_W];

   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      logic             src_vld;
      logic [NUM_W-1:0] src_num;
      logic [NUM_W-1:0] src_quo;
      logic [DEN_W-1:0] src_rem;
      logic [DEN_W-1:0] src_den;
      div_tag_type      src_tag;
      logic [DEN_W:0]   trial;
      logic             take;

      if (k == 0) begin : g_first
         assign src_vld = in_valid;
         assign src_num = in_num;
         assign src_quo = '0;
         assign src_rem = '0;
         assign src_den = in_den;
         assign src_tag = in_tag;
      end else begin : g_next
         assign src_vld = vld_ff[k-1];
         assign src_num = num_ff[k-1];
         assign src_quo = quo_ff[k-1];
         assign src_rem = rem_ff[k-1];
         assign src_den = den_ff[k-1];
         assign src_tag = tag_ff[k-1];
      end

      assign trial = {src_rem, src_num[NUM_W-1]};
      assign take  = (trial >= {1'b0, src_den});

      // The partial remainder stays below the divisor, so it fits DEN_W bits.
      assign rem_in[k] = take ? DEN_W'(trial - {1'b0, src_den}) : trial[DEN_W-1:0];
      assign num_in[k] = {src_num[NUM_W-2:0], 1'b0};
      assign quo_in[k] = {src_quo[NUM_W-2:0], take};
      assign den_in[k] = src_den;
      assign tag_in[k] = src_tag;
      assign vld_in[k] = src_vld;
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_W; k++) begin
         num_ff[k] <= num_in[k];
         quo_ff[k] <= quo_in[k];
         rem_ff[k] <= rem_in[k];
         den_ff[k] <= den_in[k];
         tag_ff[k] <= tag_in[k];
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_in[k];
         end
      end
   end

   assign out_valid = vld_ff[NUM_W-1];
   assign out_quo   = quo_ff[NUM_W-1];
   assign out_tag   = tag_ff[NUM_W-1];

endmodule

>>> hdl/temp_compensate_threshold_core.sv
// Temperature compensation core: each raw reading taken on start becomes one
// compensated temperature in tenths of a degree, a status code and two lamp
// drives. A new reading can be accepted in every cycle, and each result
// appears with rsp_valid high for one cycle, after passing through the
// divider, a 27-stage pipeline that forms one quotient bit per stage, and
// four stages ahead of it (offset, multiply, divisor sum, magnitudes) and
// four behind it (sign, sum, shift and clamp, limit compare). The receiver
// cannot stall results; busy is high only during reset. Calibration and
// limit registers are meant to be written while no transaction is in flight.
module temp_compensate_threshold_core import tct_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [RAW_W-1:0]     req_raw_reading,
   output logic                 rsp_valid,
   output logic [TEMP_W-1:0]    rsp_temperature_tenths,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic                 rsp_lamp_low,
   output logic                 rsp_lamp_high,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CAL_W-1:0]     csr_wdata
);

   // Configuration registers.
   logic        [CAL_W-1:0] cal_ac5_ff;
   logic        [CAL_W-1:0] cal_ac6_ff;
   logic signed [CAL_W-1:0] cal_mc_ff;
   logic signed [CAL_W-1:0] cal_md_ff;
   logic signed [LIM_W-1:0] limit_high_ff;
   logic signed [LIM_W-1:0] limit_low_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ac5_ff    <= CAL_AC5_RESET;
         cal_ac6_ff    <= CAL_AC6_RESET;
         cal_mc_ff     <= CAL_MC_RESET;
         cal_md_ff     <= CAL_MD_RESET;
         limit_high_ff <= LIMIT_HIGH_RESET;
         limit_low_ff  <= LIMIT_LOW_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_CAL_AC5:    cal_ac5_ff    <= csr_wdata;
            CSR_CAL_AC6:    cal_ac6_ff    <= csr_wdata;
            CSR_CAL_MC:     cal_mc_ff     <= csr_wdata;
            CSR_CAL_MD:     cal_md_ff     <= csr_wdata;
            CSR_LIMIT_HIGH: limit_high_ff <= csr_wdata[LIM_W-1:0];
            CSR_LIMIT_LOW:  limit_low_ff  <= csr_wdata[LIM_W-1:0];
            default: ;
         endcase
      end
   end

   assign busy = reset;

   // Stage 1: remove the calibration offset.
   logic                     s1_vld_ff, s1_vld_in;
   logic signed [DIFF_W-1:0] s1_diff_ff, s1_diff_in;

   assign s1_vld_in  = start && !busy;
   assign s1_diff_in = $signed({1'b0, req_raw_reading}) - $signed({1'b0, cal_ac6_ff});

   // Stage 2: scale by ac5.
   logic                     s2_vld_ff;
   logic signed [PROD_W-1:0] s2_prod_ff, s2_prod_in;

   assign s2_prod_in = s1_diff_ff * $signed({1'b0, cal_ac5_ff});

   // Stage 3: x1 is the product shifted down with floor; the divisor is x1 + md.
   logic                     s3_vld_ff;
   logic signed [X1_W-1:0]   s3_x1_ff, s3_x1_in;
   logic signed [DEN_W-1:0]  s3_den_ff, s3_den_in;

   assign s3_x1_in  = $signed(s2_prod_ff[PROD_W-1:PROD_SHIFT]);
   assign s3_den_in = $signed({s3_x1_in[X1_W-1], s3_x1_in})
                    + $signed({{(DEN_W-CAL_W){cal_md_ff[CAL_W-1]}}, cal_md_ff});

   // Stage 4: magnitudes for the unsigned divider, sign of the quotient.
   logic             s4_vld_ff;
   logic [NUM_W-1:0] s4_num_ff, s4_num_in;
   logic [DEN_W-1:0] s4_den_ff, s4_den_in;
   div_tag_type      s4_tag_ff, s4_tag_in;
   logic [CAL_W-1:0] mc_mag;

   assign mc_mag    = cal_mc_ff[CAL_W-1] ? CAL_W'(-cal_mc_ff) : cal_mc_ff;
   assign s4_num_in = {mc_mag, {MC_SHIFT{1'b0}}};
   assign s4_den_in = s3_den_ff[DEN_W-1] ? DEN_W'(-s3_den_ff) : s3_den_ff;
   assign s4_tag_in = '{x1:       s3_x1_ff,
                        div_zero: (s3_den_ff == '0),
                        quo_neg:  cal_mc_ff[CAL_W-1] ^ s3_den_ff[DEN_W-1]};

   always_ff @(posedge clock) begin
      s1_diff_ff <= s1_diff_in;
      s2_prod_ff <= s2_prod_in;
      s3_x1_ff   <= s3_x1_in;
      s3_den_ff  <= s3_den_in;
      s4_num_ff  <= s4_num_in;
      s4_den_ff  <= s4_den_in;
      s4_tag_ff  <= s4_tag_in;
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
      end
   end

   logic             div_vld;
   logic [NUM_W-1:0] div_quo;
   div_tag_type      div_tag;

   tct_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s4_vld_ff),
      .in_num    (s4_num_ff),
      .in_den    (s4_den_ff),
      .in_tag    (s4_tag_ff),
      .out_valid (div_vld),
      .out_quo   (div_quo),
      .out_tag   (div_tag)
   );

   // Stage A: apply the sign so the quotient truncates toward zero.
   logic                    sa_vld_ff;
   logic signed [QUO_W-1:0] sa_x2_ff, sa_x2_in;
   logic signed [X1_W-1:0]  sa_x1_ff;
   logic                    sa_zero_ff;

   assign sa_x2_in = div_tag.quo_neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});

   // Stage B: b5 plus the rounding constant.
   localparam logic [SUM_W-1:0] ROUND = SUM_W'(1) << (T_SHIFT - 1);

   logic                    sb_vld_ff;
   logic signed [SUM_W-1:0] sb_sum_ff, sb_sum_in;
   logic                    sb_zero_ff;

   assign sb_sum_in = $signed({{(SUM_W-QUO_W){sa_x2_ff[QUO_W-1]}}, sa_x2_ff})
                    + $signed({{(SUM_W-X1_W){sa_x1_ff[X1_W-1]}}, sa_x1_ff})
                    + $signed(ROUND);

   // Stage C: shift down with floor, clamp to 16 bits, zero on a zero divisor.
   logic                     sc_vld_ff;
   logic signed [TEMP_W-1:0] sc_temp_ff, sc_temp_in;
   status_type               sc_status_ff, sc_status_in;
   logic signed [T_W-1:0]    t_full;
   logic [T_W-TEMP_W:0]      t_top;
   logic                     t_over;

   assign t_full = $signed(sb_sum_ff[SUM_W-1:T_SHIFT]);
   assign t_top  = t_full[T_W-1:TEMP_W-1];
   assign t_over = !((&t_top) || !(|t_top));

   always_comb begin
      if (sb_zero_ff) begin
         sc_temp_in   = '0;
         sc_status_in = STATUS_DIV_ZERO;
      end else if (t_over) begin
         sc_temp_in   = t_full[T_W-1] ? {1'b1, {(TEMP_W-1){1'b0}}} : {1'b0, {(TEMP_W-1){1'b1}}};
         sc_status_in = STATUS_SATURATED;
      end else begin
         sc_temp_in   = t_full[TEMP_W-1:0];
         sc_status_in = STATUS_OK;
      end
   end

   // Stage D: lamp rule on the value that goes out; the upper limit wins.
   logic                     rsp_valid_ff;
   logic [TEMP_W-1:0]        rsp_temp_ff;
   status_type               rsp_status_ff;
   logic                     rsp_lamp_low_ff, rsp_lamp_low_in;
   logic                     rsp_lamp_high_ff, rsp_lamp_high_in;
   logic signed [TEMP_W-1:0] lim_high_ext, lim_low_ext;

   assign lim_high_ext = {{(TEMP_W-LIM_W){limit_high_ff[LIM_W-1]}}, limit_high_ff};
   assign lim_low_ext  = {{(TEMP_W-LIM_W){limit_low_ff[LIM_W-1]}}, limit_low_ff};

   always_comb begin
      if (sc_temp_ff > lim_high_ext) begin
         rsp_lamp_low_in  = 1'b1;
         rsp_lamp_high_in = 1'b1;
      end else if (sc_temp_ff < lim_low_ext) begin
         rsp_lamp_low_in  = 1'b0;
         rsp_lamp_high_in = 1'b0;
      end else begin
         rsp_lamp_low_in  = 1'b1;
         rsp_lamp_high_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      sa_x2_ff         <= sa_x2_in;
      sa_x1_ff         <= div_tag.x1;
      sa_zero_ff       <= div_tag.div_zero;
      sb_sum_ff        <= sb_sum_in;
      sb_zero_ff       <= sa_zero_ff;
      sc_temp_ff       <= sc_temp_in;
      sc_status_ff     <= sc_status_in;
      rsp_temp_ff      <= sc_temp_ff;
      rsp_status_ff    <= sc_status_ff;
      rsp_lamp_low_ff  <= rsp_lamp_low_in;
      rsp_lamp_high_ff <= rsp_lamp_high_in;
      if (reset) begin
         sa_vld_ff    <= 1'b0;
         sb_vld_ff    <= 1'b0;
         sc_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sa_vld_ff    <= div_vld;
         sb_vld_ff    <= sa_vld_ff;
         sc_vld_ff    <= sb_vld_ff;
         rsp_valid_ff <= sc_vld_ff;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_temperature_tenths = rsp_temp_ff;
   assign rsp_status             = rsp_status_ff;
   assign rsp_lamp_low           = rsp_lamp_low_ff;
   assign rsp_lamp_high          = rsp_lamp_high_ff;

   // Every accepted transaction comes out after the fixed pipeline latency.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("result missing after pipeline latency");

   // No result without a transaction accepted that many cycles earlier.
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without a matching transaction");

   a_zero_div: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_DIV_ZERO) |-> (rsp_temperature_tenths == '0))
      else $error("zero divisor result is not zero");

   a_lamps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_lamp_low || !rsp_lamp_high))
      else $error("high lamp on without low lamp");

endmodule

>>> tb/sv/tb_temp_compensate_threshold_core.sv
`timescale 1ns / 100ps

module tb_temp_compensate_threshold_core;
   import tct_pkg::*;

   localparam int     DIRECTED_ROWS   = 42;
   localparam int     RANDOM_PHASES   = 10;
   localparam int     ITEMS_PER_PHASE = 75;
   localparam int     MAX_REPORTS     = 10;
   localparam int     END_WAIT_LIMIT  = 20 * LATENCY;
   localparam longint RAW_MAX         = (longint'(1) <<< RAW_W) - 1;
   localparam longint TEMP_MAX        = (longint'(1) <<< (TEMP_W - 1)) - 1;
   localparam longint TEMP_MIN        = -(longint'(1) <<< (TEMP_W - 1));
   localparam int     LIMIT_SPAN      = 1000;

   // Indexes that decode to no register.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_7 = 3'd7;

   typedef enum logic {ROW_READING, ROW_CSR} row_kind_type;
   typedef enum int {PHASE_TYPICAL, PHASE_DIVISOR, PHASE_ANY} phase_kind_type;

   typedef struct packed {
      logic [TEMP_W-1:0] temp;
      status_type        status;
      logic              lamp_low;
      logic              lamp_high;
   } reading_result_type;

   // A reading row carries the raw word in value; a register row carries the write data.
   typedef struct packed {
      row_kind_type         kind;
      logic [CSR_IDX_W-1:0] index;
      logic [CAL_W-1:0]     value;
      logic                 fixed;
      logic [TEMP_W-1:0]    temp;
      status_type           status;
      logic                 lamp_low;
      logic                 lamp_high;
   } stim_row_type;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [RAW_W-1:0]     req_raw_reading;
   logic                 rsp_valid;
   logic [TEMP_W-1:0]    rsp_temperature_tenths;
   logic [STATUS_W-1:0]  rsp_status;
   logic                 rsp_lamp_low;
   logic                 rsp_lamp_high;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CAL_W-1:0]     csr_wdata;

   // Shadow copy of the calibration and limit registers.
   logic [CAL_W-1:0]        cfg_ac5        = CAL_AC5_RESET;
   logic [CAL_W-1:0]        cfg_ac6        = CAL_AC6_RESET;
   logic signed [CAL_W-1:0] cfg_mc         = CAL_MC_RESET;
   logic signed [CAL_W-1:0] cfg_md         = CAL_MD_RESET;
   logic signed [LIM_W-1:0] cfg_limit_high = LIMIT_HIGH_RESET;
   logic signed [LIM_W-1:0] cfg_limit_low  = LIMIT_LOW_RESET;

   reading_result_type expected_temps[$];
   reading_result_type want_result;

   int error_count     = 0;
   int results_checked = 0;
   int readings_sent   = 0;
   int register_writes = 0;
   int div_zero_seen   = 0;
   int saturated_seen  = 0;
   int lamps_off_seen  = 0;
   int lamp_low_seen   = 0;
   int lamps_on_seen   = 0;

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{ROW_READING, '0,             16'd27898, 1'b1, 16'd150,  STATUS_OK,        1'b0, 1'b0},
      '{ROW_READING, '0,             16'd0,     1'b0, '0,       STATUS_OK,        1'b0, 1'b0},
      '{ROW_READING, '0,             16'hFFFF,  1'b0, '0,       STATUS_OK,        1'b0, 1'b0},
      '{ROW_READING, '0,             16'd23153, 1'b0, '0,       STATUS_OK,        1'b0, 1'b0},
      '{ROW_CSR,     CSR_CAL_AC5,    16'd0,     1'b0, '0,       STATUS_OK,        1'b0, 1'b0},
      '{ROW_CSR,     CSR_CAL_MD,     16'd0,     1'b0, '0,       STATUS_OK,        1'b0, 1'b0},
      '{ROW_READING, '0,             16'd12345, 1'b1, 16'd0,    STATUS_DIV_ZERO,  1'b0, 1'b0},
      '{ROW_CSR,     CSR_CAL_MC,     16'h7FFF,  1'b0, '0,       STATUS_OK,        1'b0, 1'b0},
      '{ROW_CSR,     CSR_CAL_MD,     16'd1,     1'b0, '0,       STATUS_OK,        1'b0, 1'b0},
      '{ROW_READING, '0,             16'hFFFF,  1'b1, 16'h7FFF, STATUS_SATURATED, 1'b1, 1'b1},
      '{ROW_CSR,     CSR_CAL_MC,     16'h8000,  1'b0, '0,       STATUS_OK,        1'b0, 1'b0},
      '{ROW_READING, '0,             16'd0,     1'b1, 16'h8000, STATUS_SATURATED, 1'b0, 1'b0},
      '{ROW_CSR,     CSR_CAL_MD,     16'h8000,  1'b0, '0,       STATUS_OK,        1'b0, 1'b0},
      '{ROW_READING, '0,             16'd100,   1'b0, '0,       STATUS_OK,        1'b0, 1'b0},
      '{ROW_CSR,     CSR_CAL_MD,     16'h7FFF,  1'b0, '0,       STATUS_OK,        1'b0, 1'b0},
      '{ROW_READING, '0,             16'd40000, 1'b0, '0,       STATUS_OK,        1'b0, 1'b0},
      '{ROW_CSR,     CSR_CAL_AC5,    16'hFFFF,  1'b0, '0,       STATUS_OK,        1'b0, 1'b0},
      '{ROW_CSR,     CSR_CAL_AC6,    16'd0,     1'b0, '0,       STATUS_OK,        1'b0, 1'b0},
      '{ROW_READING, '0,             16'hFFFF,  1'b0, '0,       STATUS_OK,        1'b0, 1'b0},
      '{ROW_READING, '0,             16'd0,     1'b0, '0,       STATUS_OK,        1'b0, 1'b0},
      '{ROW_CSR,     CSR_CAL_AC6,    16'hFFFF,  1'b0, '0,       STATUS_OK,        1'b0, 1'b0},
      '{ROW_READING, '0,             16'd0,     1'b0, '0,       STATUS_OK,        1'b0, 1'b0},
      '{ROW_READING, '0,             16'hFFFF,  1'b0, '0,       STATUS_OK,        1'b0, 1'b0},
      '{ROW_CSR,     CSR_CAL_AC5,    16'd32757, 1'b0, '0,       STATUS_OK,        1'b0, 1'b0},
      '{ROW_CSR,     CSR_CAL_AC6,    16'd23153, 1'b0, '0,       STATUS_OK,        1'b0, 1'b0},
      '{ROW_CSR,     CSR_CAL_MC,     16'hDDF9,  1'b0, '0,       STATUS_OK,        1'b0, 1'b0},
      '{ROW_CSR,     CSR_CAL_MD,     16'd2868,  1'b0, '0,       STATUS_OK,        1'b0, 1'b0},
      '{ROW_CSR,     CSR_LIMIT_HIGH, 16'd1000,  1'b0, '0,       STATUS_OK,        1'b0, 1'b0},
      '{ROW_CSR,     CSR_LIMIT_LOW,  16'hFC18,  1'b0, '0,       STATUS_OK,        1'b0, 1'b0},
      '{ROW_READING, '0,             16'd27898, 1'b0, '0,       STATUS_OK,        1'b0, 1'b0},
      '{ROW_READING, '0,             16'hFFFF,  1'b0, '0,       STATUS_OK,        1'b0, 1'b0},
      '{ROW_READING, '0,             16'd0,     1'b0, '0,       STATUS_OK,        1'b0, 1'b0},
      '{ROW_CSR,     CSR_LIMIT_HIGH, 16'hFC18,  1'b0, '0,       STATUS_OK,        1'b0, 1'b0},
      '{ROW_CSR,     CSR_LIMIT_LOW,  16'd1000,  1'b0, '0,       STATUS_OK,        1'b0, 1'b0},
      '{ROW_READING, '0,             16'd27898, 1'b0, '0,       STATUS_OK,        1'b0, 1'b0},
      '{ROW_READING, '0,             16'd0,     1'b0, '0,       STATUS_OK,        1'b0, 1'b0},
      '{ROW_CSR,     CSR_LIMIT_HIGH, 16'd150,   1'b0, '0,       STATUS_OK,        1'b0, 1'b0},
      '{ROW_CSR,     CSR_LIMIT_LOW,  16'd150,   1'b0, '0,       STATUS_OK,        1'b0, 1'b0},
      '{ROW_READING, '0,             16'd27898, 1'b1, 16'd150,  STATUS_OK,        1'b1, 1'b0},
      '{ROW_CSR,     CSR_SPARE_6,    16'hFFFF,  1'b0, '0,       STATUS_OK,        1'b0, 1'b0},
      '{ROW_CSR,     CSR_SPARE_7,    16'h0000,  1'b0, '0,       STATUS_OK,        1'b0, 1'b0},
      '{ROW_READING, '0,             16'd27898, 1'b1, 16'd150,  STATUS_OK,        1'b1, 1'b0}
   };

   temp_compensate_threshold_core i_dut (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_raw_reading        (req_raw_reading),
      .rsp_valid              (rsp_valid),
      .rsp_temperature_tenths (rsp_temperature_tenths),
      .rsp_status             (rsp_status),
      .rsp_lamp_low           (rsp_lamp_low),
      .rsp_lamp_high          (rsp_lamp_high),
      .csr_we                 (csr_we),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic reading_result_type compensate_reading(input logic [RAW_W-1:0] raw);
      longint             x1;
      longint             divisor;
      longint             quotient;
      longint             t;
      reading_result_type r;
      x1       = ((longint'(raw) - longint'(cfg_ac6)) * longint'(cfg_ac5)) >>> PROD_SHIFT;
      divisor  = x1 + longint'(cfg_md);
      r.status = STATUS_OK;
      if (divisor == 0) begin
         t        = 0;
         r.status = STATUS_DIV_ZERO;
      end else begin
         quotient = (longint'(cfg_mc) <<< MC_SHIFT) / divisor;
         t = (x1 + quotient + (longint'(1) <<< (T_SHIFT - 1))) >>> T_SHIFT;
         if (t > TEMP_MAX) begin
            t        = TEMP_MAX;
            r.status = STATUS_SATURATED;
         end else if (t < TEMP_MIN) begin
            t        = TEMP_MIN;
            r.status = STATUS_SATURATED;
         end
      end
      // The upper limit wins when the limits are crossed.
      r.lamp_high = (t > longint'(cfg_limit_high));
      r.lamp_low  = r.lamp_high || !(t < longint'(cfg_limit_low));
      r.temp      = t[TEMP_W-1:0];
      return r;
   endfunction

   function automatic int unsigned pick_gap(input bit no_idle);
      int unsigned roll;
      if (no_idle) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 40);
      return $urandom_range(41, 150);
   endfunction

   task automatic send_reading(input logic [RAW_W-1:0] raw, input bit use_fixed,
                               input reading_result_type fixed_result,
                               input int unsigned gap);
      reading_result_type want;
      want = use_fixed ? fixed_result : compensate_reading(raw);
      csr_we          <= 1'b0;
      start           <= 1'b1;
      req_raw_reading <= raw;
      do @(posedge clock); while (busy);
      expected_temps.push_back(want);
      readings_sent++;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Every reading yields a result, so an empty queue means nothing is in flight.
   // With an empty queue start is already low, since the last result took a full
   // pipeline latency of idle or waiting cycles to come out.
   task automatic drain_readings();
      if (expected_temps.size() != 0) begin
         start <= 1'b0;
         while (expected_temps.size() != 0) @(posedge clock);
      end
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CAL_W-1:0] value);
      csr_index <= index;
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(posedge clock);
      register_writes++;
      case (index)
         CSR_CAL_AC5:    cfg_ac5 = value;
         CSR_CAL_AC6:    cfg_ac6 = value;
         CSR_CAL_MC:     cfg_mc = value;
         CSR_CAL_MD:     cfg_md = value;
         CSR_LIMIT_HIGH: cfg_limit_high = value[LIM_W-1:0];
         CSR_LIMIT_LOW:  cfg_limit_low = value[LIM_W-1:0];
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_temps.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
               $display("ERROR: result with no pending transaction: temp %0d status %0d",
                        $signed(rsp_temperature_tenths), rsp_status);
            end
         end else begin
            want_result = expected_temps.pop_front();
            results_checked++;
            if (want_result.status == STATUS_DIV_ZERO) div_zero_seen++;
            if (want_result.status == STATUS_SATURATED) saturated_seen++;
            if (want_result.lamp_high) lamps_on_seen++;
            else if (want_result.lamp_low) lamp_low_seen++;
            else lamps_off_seen++;
            if (rsp_temperature_tenths !== want_result.temp ||
                rsp_status !== want_result.status ||
                rsp_lamp_low !== want_result.lamp_low ||
                rsp_lamp_high !== want_result.lamp_high) begin
               error_count++;
               if (error_count <= MAX_REPORTS) begin
                  $display("ERROR: result %0d: expected temp %0d status %0d lamps %b%b, got temp %0d status %0d lamps %b%b",
                           results_checked, $signed(want_result.temp), want_result.status,
                           want_result.lamp_low, want_result.lamp_high,
                           $signed(rsp_temperature_tenths), rsp_status,
                           rsp_lamp_low, rsp_lamp_high);
               end
            end
         end
      end
   end

   initial begin
      reading_result_type row_result;
      phase_kind_type     phase_kind;
      longint             target;
      int                 lim_lo;
      int                 lim_hi;
      int                 swap;
      int                 waited;
      bit                 no_idle;

      reset           <= 1'b1;
      start           <= 1'b0;
      req_raw_reading <= '0;
      csr_we          <= 1'b0;
      csr_index       <= '0;
      csr_wdata       <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            drain_readings();
            write_register(directed_rows[i].index, directed_rows[i].value);
         end else begin
            row_result = '{directed_rows[i].temp, directed_rows[i].status,
                           directed_rows[i].lamp_low, directed_rows[i].lamp_high};
            send_reading(directed_rows[i].value, directed_rows[i].fixed, row_result,
                         pick_gap(1'b0));
         end
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         phase_kind = phase_kind_type'(phase % 3);
         drain_readings();
         case (phase_kind)
            PHASE_TYPICAL: begin
               write_register(CSR_CAL_AC5,
                              CAL_AC5_RESET - 16'd2000 + 16'($urandom_range(0, 4000)));
               write_register(CSR_CAL_AC6, 16'($urandom_range(15000, 30000)));
               write_register(CSR_CAL_MC, 16'(-int'($urandom_range(4000, 16000))));
               write_register(CSR_CAL_MD, 16'($urandom_range(1500, 4500)));
            end
            PHASE_DIVISOR: begin
               // A scale of exactly 2^15 makes x1 the plain offset, so the divisor can be aimed at.
               write_register(CSR_CAL_AC5, 16'h8000);
               write_register(CSR_CAL_AC6, 16'($urandom));
               write_register(CSR_CAL_MC, 16'($urandom));
               write_register(CSR_CAL_MD, 16'($urandom));
            end
            default: begin
               write_register(CSR_CAL_AC5, 16'($urandom));
               write_register(CSR_CAL_AC6, 16'($urandom));
               write_register(CSR_CAL_MC, 16'($urandom));
               write_register(CSR_CAL_MD, 16'($urandom));
            end
         endcase
         lim_lo = int'($urandom_range(0, 2 * LIMIT_SPAN)) - LIMIT_SPAN;
         lim_hi = lim_lo + int'($urandom_range(0, 800));
         if (lim_hi > LIMIT_SPAN) lim_hi = LIMIT_SPAN;
         if ($urandom_range(0, 4) == 0) begin
            swap   = lim_lo;
            lim_lo = lim_hi;
            lim_hi = swap;
         end
         write_register(CSR_LIMIT_HIGH, 16'(lim_hi));
         write_register(CSR_LIMIT_LOW, 16'(lim_lo));
         if ($urandom_range(0, 2) == 0) begin
            write_register($urandom_range(0, 1) ? CSR_SPARE_6 : CSR_SPARE_7, 16'($urandom));
         end

         no_idle = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            case (phase_kind)
               PHASE_TYPICAL:
                  target = longint'(cfg_ac6) + longint'($urandom_range(0, 32000)) - 16000;
               PHASE_DIVISOR:
                  target = $urandom_range(0, 1) ?
                           longint'(cfg_ac6) - longint'(cfg_md) +
                           longint'($urandom_range(0, 6)) - 3 :
                           longint'($urandom_range(0, 65535));
               default:
                  target = longint'($urandom_range(0, 65535));
            endcase
            if (target < 0 || target > RAW_MAX || $urandom_range(0, 9) == 0) begin
               target = longint'($urandom_range(0, 65535));
            end
            if ($urandom_range(0, 149) == 0) drain_readings();
            send_reading(target[RAW_W-1:0], 1'b0, '0, pick_gap(no_idle));
         end
      end

      start  <= 1'b0;
      waited = 0;
      while (expected_temps.size() != 0 && waited < END_WAIT_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (LATENCY + 4) @(posedge clock);
      if (expected_temps.size() != 0) begin
         error_count++;
         $display("ERROR: %0d transactions never produced a result", expected_temps.size());
      end

      $display("Sent %0d readings, checked %0d results, made %0d register writes.",
               readings_sent, results_checked, register_writes);
      $display("Zero divisor %0d, saturated %0d; lamps off %0d, low only %0d, both on %0d.",
               div_zero_seen, saturated_seen, lamps_off_seen, lamp_low_seen, lamps_on_seen);
      if (error_count == 0) begin
         $display("temp_compensate_threshold_core regression: pass");
      end else begin
         $display("temp_compensate_threshold_core regression: fail");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("Timed out waiting for the run to complete.");
      $display("temp_compensate_threshold_core regression: fail");
      $finish;
   end

endmodule
